FILE: rtl/core/i2cmbs_pkg.sv
// package for the i2c master bit sequencer
// holds command codes, register indexes, reset values and the phase type
// no dependencies
`timescale 1ns / 1ps

package i2cmbs_pkg;

  // command codes carried by the kind field
  localparam logic [2:0] KindTick    = 3'd0;
  localparam logic [2:0] KindStart   = 3'd1;
  localparam logic [2:0] KindStop    = 3'd2;
  localparam logic [2:0] KindWrite   = 3'd3;
  localparam logic [2:0] KindRead    = 3'd4;
  localparam logic [2:0] KindWaitAck = 3'd5;

  // register index, taken from paddr[2]
  localparam logic CfgHalfPeriod = 1'b0;
  localparam logic CfgAckTimeout = 1'b1;

  localparam int unsigned HalfPeriodW = 8;
  localparam int unsigned AckTimeoutW = 10;
  localparam int unsigned ApbDataW    = 32;
  localparam int unsigned ApbAddrW    = 3;

  localparam logic [HalfPeriodW-1:0] HalfPeriodRst = 8'd4;
  localparam logic [AckTimeoutW-1:0] AckTimeoutRst = 10'd250;

  // command sequencer phases, one-hot
  typedef enum logic [14:0] {
    PhIdle   = 15'b000000000000001,
    PhStA    = 15'b000000000000010,
    PhStB    = 15'b000000000000100,
    PhSpA    = 15'b000000000001000,
    PhSpB    = 15'b000000000010000,
    PhWrSet  = 15'b000000000100000,
    PhWrHigh = 15'b000000001000000,
    PhWrLow  = 15'b000000010000000,
    PhRdLow  = 15'b000000100000000,
    PhRdHigh = 15'b000001000000000,
    PhAkLow  = 15'b000010000000000,
    PhAkHigh = 15'b000100000000000,
    PhWaRel  = 15'b001000000000000,
    PhWaHigh = 15'b010000000000000,
    PhWaPoll = 15'b100000000000000
  } phase_e;

endpackage

FILE: rtl/core/i2c_master_bit_sequencer.sv
// top level of the i2c master bit sequencer
// depends on i2cmbs_pkg for command codes, register indexes and the phase type
`timescale 1ns / 1ps

// i2c master line sequencer driven by time ticks. every input transaction is
// one tick: it carries the sampled sda level and, while the sequencer is idle,
// a command (start, stop, write byte msb first, read byte then ack/nack, or
// wait for the slave ack). every input transaction gives exactly one output
// transaction holding the scl level, sda level and drive enable, busy, a done
// pulse, the last received byte and the ack failure flag, all as they stand
// after that tick. the block takes one tick per clock cycle while the result
// channel is not stalled: an input register feeds the sequencer, whose update
// lands in the state and result registers, where a result stands until taken.
// while a result is stalled one more tick can be held in the input register.
// half_period_ticks (address 0) sets the hold per line change and ack_timeout
// (address 4) the number of high polls tolerated by wait-ack; both should be
// written only while no tick is in flight.
// there is no clearing pass after reset.
module i2c_master_bit_sequencer
  import i2cmbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  // apb configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,

  // tick input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          data_byte_i,
  input  logic                send_ack_i,
  input  logic                sda_in_i,

  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                scl_level_o,
  output logic                sda_level_o,
  output logic                sda_drive_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [7:0]          rx_byte_o,
  output logic                ack_fail_o
);

  // configuration registers
  logic [HalfPeriodW-1:0] half_period_q;
  logic [AckTimeoutW-1:0] ack_timeout_q;
  logic                   cfg_wr;

  // input register
  logic       in_valid_q;
  logic [2:0] kind_q;
  logic [7:0] data_q;
  logic       send_ack_q;
  logic       sda_q;

  // sequencer state, which doubles as the result register
  phase_e     phase_q, phase_d;
  logic [7:0] timer_q, timer_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic [7:0] shift_q, shift_d;
  logic [AckTimeoutW-1:0] poll_q, poll_d;
  logic       scl_q, scl_d;
  logic       sda_lvl_q, sda_lvl_d;
  logic       drv_q, drv_d;
  logic       ack_flag_q, ack_flag_d;
  logic       ack_choice_q, ack_choice_d;
  logic [7:0] rx_q, rx_d;
  logic       done_q, done_d;
  logic       out_valid_q;

  logic       in_accept;
  logic       advance;
  logic       fire;
  logic [7:0] hold;

  // ---------------------------------------------------------------------------
  // apb port: writes land on the access cycle, reads are combinational
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HalfPeriodRst;
      ack_timeout_q <= AckTimeoutRst;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CfgHalfPeriod: half_period_q <= pwdata[HalfPeriodW-1:0];
        CfgAckTimeout: ack_timeout_q <= pwdata[AckTimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CfgHalfPeriod: prdata = {{(ApbDataW-HalfPeriodW){1'b0}}, half_period_q};
      CfgAckTimeout: prdata = {{(ApbDataW-AckTimeoutW){1'b0}}, ack_timeout_q};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // flow control: the sequencer steps when a tick sits in the input register
  // and the result register is free or being drained this cycle
  // ---------------------------------------------------------------------------
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q     <= kind_i;
      data_q     <= data_byte_i;
      send_ack_q <= send_ack_i;
      sda_q      <= sda_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // a zero half period behaves as one tick
  assign hold = (half_period_q == '0) ? 8'd1 : half_period_q;

  // ---------------------------------------------------------------------------
  // sequencer next state for one tick
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    bit_cnt_d    = bit_cnt_q;
    shift_d      = shift_q;
    poll_d       = poll_q;
    scl_d        = scl_q;
    sda_lvl_d    = sda_lvl_q;
    drv_d        = drv_q;
    ack_flag_d   = ack_flag_q;
    ack_choice_d = ack_choice_q;
    rx_d         = rx_q;
    done_d       = 1'b0;

    if (phase_q == PhIdle) begin
      // commands are only looked at while idle
      unique case (kind_q)
        KindStart: begin
          scl_d     = 1'b1;
          sda_lvl_d = 1'b1;
          drv_d     = 1'b1;
          phase_d   = PhStA;
          timer_d   = hold;
        end
        KindStop: begin
          scl_d     = 1'b0;
          sda_lvl_d = 1'b0;
          drv_d     = 1'b1;
          phase_d   = PhSpA;
          timer_d   = hold;
        end
        KindWrite: begin
          bit_cnt_d = '0;
          scl_d     = 1'b0;
          sda_lvl_d = data_q[7];
          drv_d     = 1'b1;
          shift_d   = {data_q[6:0], 1'b0};
          phase_d   = PhWrSet;
          timer_d   = hold;
        end
        KindRead: begin
          ack_choice_d = send_ack_q;
          bit_cnt_d    = '0;
          shift_d      = '0;
          scl_d        = 1'b0;
          drv_d        = 1'b0;
          phase_d      = PhRdLow;
          timer_d      = hold;
        end
        KindWaitAck: begin
          ack_flag_d = 1'b0;
          poll_d     = '0;
          sda_lvl_d  = 1'b1;
          drv_d      = 1'b0;
          phase_d    = PhWaRel;
          timer_d    = 8'd1;
        end
        default: ;
      endcase
    end else if (phase_q == PhWaPoll) begin
      // one sda poll per tick
      if (!sda_q) begin
        scl_d      = 1'b0;
        sda_lvl_d  = 1'b1;
        drv_d      = 1'b0;
        ack_flag_d = 1'b0;
        phase_d    = PhIdle;
        timer_d    = '0;
        done_d     = 1'b1;
      end else if (poll_q >= ack_timeout_q) begin
        // give up: flag failure and run a stop
        ack_flag_d = 1'b1;
        scl_d      = 1'b0;
        sda_lvl_d  = 1'b0;
        drv_d      = 1'b1;
        phase_d    = PhSpA;
        timer_d    = hold;
      end else begin
        poll_d = poll_q + 1'b1;
      end
    end else if (timer_q > 8'd1) begin
      timer_d = timer_q - 8'd1;
    end else begin
      unique case (phase_q)
        PhStA: begin
          sda_lvl_d = 1'b0;
          drv_d     = 1'b1;
          scl_d     = 1'b1;
          phase_d   = PhStB;
          timer_d   = hold;
        end
        PhStB: begin
          scl_d     = 1'b0;
          sda_lvl_d = 1'b0;
          drv_d     = 1'b1;
          phase_d   = PhIdle;
          timer_d   = '0;
          done_d    = 1'b1;
        end
        PhSpA: begin
          scl_d     = 1'b1;
          sda_lvl_d = 1'b1;
          drv_d     = 1'b1;
          phase_d   = PhSpB;
          timer_d   = hold;
        end
        PhWrSet: begin
          scl_d   = 1'b1;
          phase_d = PhWrHigh;
          timer_d = hold;
        end
        PhWrHigh: begin
          scl_d   = 1'b0;
          phase_d = PhWrLow;
          timer_d = hold;
        end
        PhWrLow: begin
          if (bit_cnt_q == 3'd7) begin
            bit_cnt_d = '0;
            phase_d   = PhIdle;
            timer_d   = '0;
            done_d    = 1'b1;
          end else begin
            bit_cnt_d = bit_cnt_q + 3'd1;
            scl_d     = 1'b0;
            sda_lvl_d = shift_q[7];
            drv_d     = 1'b1;
            shift_d   = {shift_q[6:0], 1'b0};
            phase_d   = PhWrSet;
            timer_d   = hold;
          end
        end
        PhRdLow: begin
          scl_d   = 1'b1;
          phase_d = PhRdHigh;
          timer_d = hold;
        end
        PhRdHigh: begin
          // sample at the end of the high hold
          shift_d = {shift_q[6:0], sda_q};
          if (bit_cnt_q == 3'd7) begin
            bit_cnt_d = '0;
            scl_d     = 1'b0;
            sda_lvl_d = ~ack_choice_q;
            drv_d     = 1'b1;
            phase_d   = PhAkLow;
          end else begin
            bit_cnt_d = bit_cnt_q + 3'd1;
            scl_d     = 1'b0;
            phase_d   = PhRdLow;
          end
          timer_d = hold;
        end
        PhAkLow: begin
          scl_d   = 1'b1;
          phase_d = PhAkHigh;
          timer_d = hold;
        end
        PhAkHigh: begin
          scl_d   = 1'b0;
          rx_d    = shift_q;
          phase_d = PhIdle;
          timer_d = '0;
          done_d  = 1'b1;
        end
        PhWaRel: begin
          scl_d   = 1'b1;
          phase_d = PhWaHigh;
          timer_d = 8'd1;
        end
        PhWaHigh: begin
          phase_d = PhWaPoll;
          timer_d = '0;
        end
        default: begin
          // end of stop, and any stray code, finishes the command
          phase_d = PhIdle;
          timer_d = '0;
          done_d  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      timer_q      <= '0;
      bit_cnt_q    <= '0;
      shift_q      <= '0;
      poll_q       <= '0;
      scl_q        <= 1'b1;
      sda_lvl_q    <= 1'b1;
      drv_q        <= 1'b1;
      ack_flag_q   <= 1'b0;
      ack_choice_q <= 1'b0;
      rx_q         <= '0;
      done_q       <= 1'b0;
    end else if (fire) begin
      phase_q      <= phase_d;
      timer_q      <= timer_d;
      bit_cnt_q    <= bit_cnt_d;
      shift_q      <= shift_d;
      poll_q       <= poll_d;
      scl_q        <= scl_d;
      sda_lvl_q    <= sda_lvl_d;
      drv_q        <= drv_d;
      ack_flag_q   <= ack_flag_d;
      ack_choice_q <= ack_choice_d;
      rx_q         <= rx_d;
      done_q       <= done_d;
    end
  end

  // state only moves on a step, so it stands as the result while stalled
  assign out_valid_o = out_valid_q;
  assign scl_level_o = scl_q;
  assign sda_level_o = sda_lvl_q;
  assign sda_drive_o = drv_q;
  assign busy_res_o  = (phase_q != PhIdle);
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_q;
  assign ack_fail_o  = ack_flag_q;

`ifndef SYNTHESIS
  // a done pulse is only reported once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> (phase_q == PhIdle))
    else $error("done reported while a command is still running");

  // the bit counter is cleared whenever a command has finished
  a_idle_bitcnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (bit_cnt_q == '0))
    else $error("bit counter left non-zero at idle");

  // every timed phase carries a live hold count
  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q != PhIdle) && (phase_q != PhWaPoll)) |-> (timer_q != '0))
    else $error("timed phase with a zero hold count");

  // a stalled result freezes the sequencer
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(phase_q)
      && $stable(timer_q)))
    else $error("sequencer moved while its result was stalled");
`endif

endmodule
